/* src/swm_pkg.sv */
// Shared types and constants for the sliding window maximum unit.
// Used by the cell row, the output stage and the top level; no dependencies.
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int WIN_WIDTH    = 7;
   localparam int CNT_WIDTH    = $clog2(MAX_WINDOW + 1);
   localparam int IDX_WIDTH    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = WIN_WIDTH'(3);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic       valid;
      sample_type value;
   } swm_link_type;

endpackage

/* src/swm_cell.sv */
// One cell of the running-maximum row: holds the maximum of the newest samples
// up to its own depth. Depends on swm_pkg.
module swm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic                 restart,
   input  logic                 first_cell,
   input  swm_pkg::sample_type  sample,
   input  swm_pkg::swm_link_type prev_link,
   output swm_pkg::swm_link_type link,
   output swm_pkg::sample_type  next_max
);
   import swm_pkg::*;

   logic       valid_ff;
   sample_type value_ff;
   sample_type value_in;
   logic       chain;

   always_comb begin
      chain = prev_link.valid && !restart && !first_cell;
      if (chain && (prev_link.value > sample)) begin
         value_in = prev_link.value;
      end else begin
         value_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign link.valid = valid_ff;
   assign link.value = value_ff;
   assign next_max   = value_in;

endmodule

/* src/swm_out_stage.sv */
// Two-entry output stage that holds results while the consumer stalls.
// Depends on swm_pkg.
module swm_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  swm_pkg::sample_type in_data,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output swm_pkg::sample_type out_data
);
   import swm_pkg::*;

   logic       main_valid_ff;
   logic       skid_valid_ff;
   sample_type main_data_ff;
   sample_type skid_data_ff;
   logic       advance;

   assign advance = !main_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (skid_valid_ff) begin
            main_data_ff <= skid_data_ff;
         end else begin
            main_data_ff <= in_data;
         end
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

/* src/sliding_window_maximum_unit.sv */
// Top level of the sliding window maximum unit: cell row, sample counter,
// window register and output stage. Depends on swm_pkg, swm_cell, swm_out_stage.
//
// The unit takes one sample per clock while the output stage has room and
// registers a window maximum there once window_size samples have been counted
// since the last restart; the count saturates at the window size in force.
// Each cell of a row of MAX_WINDOW cells keeps the maximum of the newest
// samples up to its depth and passes it to the next cell on every accepted
// sample. A sample that has dropped out of the window stays out when the
// window later grows, so the window fills again one sample at a time: the
// live depth follows min(depth + 1, window_size) per sample and starts over on
// a restart, and the result is the new value of the cell at the live depth
// minus one. The compare in a cell plus the selection across the row sets the
// clock period. A two-entry output stage lets the next sample in while a
// result waits, so input stalls only when two results are held. Window sizes
// of zero read as one and sizes above MAX_WINDOW read as MAX_WINDOW. The
// window register may be written only while the unit is idle.
module sliding_window_maximum_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  swm_pkg::sample_type         req_sample,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output swm_pkg::sample_type         rsp_window_max,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [swm_pkg::WIN_WIDTH-1:0] csr_window_size
);
   import swm_pkg::*;

   logic [WIN_WIDTH-1:0] window_ff;
   logic [CNT_WIDTH-1:0] seen_count_ff;
   logic [CNT_WIDTH-1:0] seen_count_in;
   logic [CNT_WIDTH-1:0] live_len_ff;
   logic [CNT_WIDTH-1:0] live_len_in;
   logic [CNT_WIDTH-1:0] window_eff;
   logic [IDX_WIDTH-1:0] tap_index;
   logic                 accept;
   logic                 result_valid;
   sample_type           next_max [MAX_WINDOW];
   swm_link_type         links [MAX_WINDOW + 1];

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_window_size;
      end
   end

   always_comb begin
      if (window_ff == '0) begin
         window_eff = CNT_WIDTH'(1);
      end else if ({1'b0, window_ff} > (WIN_WIDTH + 1)'(MAX_WINDOW)) begin
         window_eff = CNT_WIDTH'(MAX_WINDOW);
      end else begin
         window_eff = CNT_WIDTH'(window_ff);
      end
   end

   always_comb begin
      seen_count_in = req_restart ? '0 : seen_count_ff;
      if (seen_count_in < window_eff) begin
         seen_count_in = seen_count_in + CNT_WIDTH'(1);
      end
      result_valid = accept && (seen_count_in >= window_eff);
   end

   always_comb begin
      live_len_in = req_restart ? '0 : live_len_ff;
      if (live_len_in < window_eff) begin
         live_len_in = live_len_in + CNT_WIDTH'(1);
      end else begin
         live_len_in = window_eff;
      end
      tap_index = IDX_WIDTH'(live_len_in - CNT_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         live_len_ff   <= '0;
      end else if (accept) begin
         seen_count_ff <= seen_count_in;
         live_len_ff   <= live_len_in;
      end
   end

   assign links[0] = '0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cells
      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .restart    (req_restart),
         .first_cell (i == 0),
         .sample     (req_sample),
         .prev_link  (links[i]),
         .link       (links[i + 1]),
         .next_max   (next_max[i])
      );
   end

   swm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (next_max[tap_index]),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_window_max)
   );

   // The output stage only refuses input while a result is being presented.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result presented");

   // A new result appears only after a transaction was accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted transaction");

   // A restart sample leaves exactly one sample counted.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_restart) |=> (seen_count_ff == CNT_WIDTH'(1)))
      else $error("restart did not reset the sample count");

   // The sample count never exceeds the largest window.
   assert property (@(posedge clock) disable iff (reset)
      seen_count_ff <= CNT_WIDTH'(MAX_WINDOW))
      else $error("sample count exceeds the largest window");

endmodule

/* tb/sv/tb_sliding_window_maximum_unit.sv */
// Self-checking testbench for sliding_window_maximum_unit: directed and random sample streams
// with random idling on both channels, checked against a monotonic queue predictor.
// Depends on swm_pkg and the sliding_window_maximum_unit RTL.
module tb_sliding_window_maximum_unit;
   import swm_pkg::*;

   localparam int DEPTH      = MAX_WINDOW;
   localparam int POS_MOD    = 2 * MAX_WINDOW;
   localparam int PHASES     = 16;
   localparam int DRAIN      = 4;
   localparam int IDLE_LIMIT = 2000;
   localparam int PROBES     = 24;
   localparam int DUE_DEPTH  = 8;

   typedef struct packed {
      sample_type sample;
      logic       restart;
      logic       typed;
      sample_type max;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sample_type           req_sample = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   sample_type           rsp_window_max;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [WIN_WIDTH-1:0] csr_window_size = '0;

   logic                 req_typed = 1'b0;
   sample_type           req_typed_max = '0;
   bit                   steady = 1'b0;

   sample_type           cand_vals [DEPTH];
   logic [6:0]           cand_pos [DEPTH];
   int                   cand_head = 0;
   int                   cand_len = 0;
   int                   next_pos = 0;
   int                   seen_run = 0;
   logic [WIN_WIDTH-1:0] window_reg = WINDOW_RESET;

   sample_type           maxima_due [DUE_DEPTH];
   int                   due_head = 0;
   int                   due_count = 0;
   int                   failures = 0;
   int                   maxima_checked = 0;
   int                   samples_taken = 0;
   int                   restarts_taken = 0;

   probe_row_type probe_table [PROBES] = '{
      '{16'sh8000, 1'b1, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b1, 16'sh7FFF},
      '{16'sh8000, 1'b0, 1'b1, 16'sh7FFF},
      '{16'sh0000, 1'b0, 1'b1, 16'sh0000},
      '{16'sh0005, 1'b0, 1'b1, 16'sh0005},
      '{16'sh0005, 1'b0, 1'b1, 16'sh0005},
      '{16'sh0005, 1'b0, 1'b1, 16'sh0005},
      '{16'shFFFF, 1'b0, 1'b1, 16'sh0005},
      '{16'shFFFF, 1'b0, 1'b1, 16'sh0005},
      '{16'shFFFF, 1'b0, 1'b1, 16'shFFFF},
      '{16'sh5555, 1'b1, 1'b0, 16'sh0000},
      '{16'shAAAA, 1'b0, 1'b0, 16'sh0000},
      '{16'sh012C, 1'b0, 1'b1, 16'sh5555},
      '{16'sh012B, 1'b0, 1'b1, 16'sh012C},
      '{16'sh012A, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0129, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0129, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b1, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b1, 16'sh8000},
      '{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF}
   };

   sliding_window_maximum_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_max  (rsp_window_max),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_window(input logic [WIN_WIDTH-1:0] w);
      if (w == 0) return 1;
      if (w > DEPTH) return DEPTH;
      return int'(w);
   endfunction

   // Updates the candidate queue with one sample and returns 1 when a window maximum is due.
   function automatic bit advance_window(input sample_type s, input bit restart,
                                         output sample_type window_max);
      int w;
      int age;
      w = effective_window(window_reg);
      if (restart) begin
         cand_head = 0;
         cand_len  = 0;
         next_pos  = 0;
         seen_run  = 0;
      end
      while (cand_len > 0 && cand_vals[(cand_head + cand_len - 1) % DEPTH] <= s)
         cand_len--;
      while (cand_len > 0) begin
         age = (next_pos + POS_MOD - int'(cand_pos[cand_head])) % POS_MOD;
         if (age < w) break;
         cand_head = (cand_head + 1) % DEPTH;
         cand_len--;
      end
      cand_vals[(cand_head + cand_len) % DEPTH] = s;
      cand_pos[(cand_head + cand_len) % DEPTH]  = 7'(next_pos);
      cand_len++;
      next_pos = (next_pos + 1) % POS_MOD;
      if (seen_run < w) seen_run++;
      window_max = cand_vals[cand_head];
      return seen_run >= w;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_failure(input string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
   endtask

   always @(posedge clock) begin
      sample_type predicted;
      sample_type due;
      bit         has_max;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_count == 0) begin
               flag_failure($sformatf("unexpected window max %0d", rsp_window_max));
            end else begin
               due       = maxima_due[due_head];
               due_head  = (due_head + 1) % DUE_DEPTH;
               due_count--;
               maxima_checked++;
               if (rsp_window_max !== due)
                  flag_failure($sformatf("window max expected %0d, got %0d",
                                         due, rsp_window_max));
            end
         end
         if (req_valid && req_ready) begin
            has_max = advance_window(req_sample, req_restart, predicted);
            samples_taken++;
            if (req_restart) restarts_taken++;
            if (req_typed || has_max) begin
               if (due_count == DUE_DEPTH) begin
                  flag_failure("too many window maxima outstanding");
               end else begin
                  maxima_due[(due_head + due_count) % DUE_DEPTH] =
                     req_typed ? req_typed_max : predicted;
                  due_count++;
               end
            end
         end
         if (csr_valid && csr_ready) window_reg = csr_window_size;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = idle_len();
         rsp_ready <= (stall_left == 0);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_sample(input sample_type s, input bit restart, input bit typed,
                              input sample_type typed_max);
      int gap;
      req_sample    <= s;
      req_restart   <= restart;
      req_typed     <= typed;
      req_typed_max <= typed_max;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_WIDTH-1:0] w);
      csr_window_size <= w;
      csr_valid       <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [WIN_WIDTH-1:0] plan [8];
      logic [WIN_WIDTH-1:0] w;
      sample_type           s;
      bit                   restart;
      int                   count;
      int                   odds;
      int                   style;
      int                   style_left;
      plan = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd33, 7'd4};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i])
         send_sample(probe_table[i].sample, probe_table[i].restart,
                     probe_table[i].typed, probe_table[i].max);

      s          = '0;
      style      = 0;
      style_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         if (phase < 8) w = plan[phase];
         else if ($urandom_range(0, 3) == 0) w = 7'($urandom_range(0, 127));
         else w = 7'($urandom_range(1, 64));
         write_window(w);
         steady = (phase % 5 == 2);
         count  = (effective_window(w) >= 32) ? $urandom_range(120, 180)
                                              : $urandom_range(70, 110);
         odds   = (phase % 4 == 3) ? 5 : 3 * effective_window(w) + 40;
         for (int k = 0; k < count; k++) begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 4);
               style_left = $urandom_range(4, 24);
            end
            style_left--;
            case (style)
               0: s = sample_type'($urandom);
               1: s = sample_type'($urandom_range(0, 8)) - 16'sd4;
               2: s = s - sample_type'($urandom_range(0, 3));
               3: s = s + sample_type'($urandom_range(0, 50));
               default: begin
                  case ($urandom_range(0, 3))
                     0: s = 16'sh8000;
                     1: s = 16'sh7FFF;
                     2: s = 16'sh0000;
                     default: s = 16'shFFFF;
                  endcase
               end
            endcase
            if (k == 0) restart = $urandom_range(0, 1);
            else restart = ($urandom_range(0, odds) == 0);
            send_sample(s, restart, 1'b0, '0);
         end
      end
      settle();

      $display("Covered %0d samples with %0d restarts over %0d window settings.",
               samples_taken, restarts_taken, PHASES + 1);
      $display("Compared %0d window maxima, %0d failures.", maxima_checked, failures);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
